/* src/assert_macros.svh */
// Assertion macros shared by the map engine RTL.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Property holds at every clock edge outside reset.
`define EPTM_ASSERT(lbl, clk, rstn, prop, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rstn) (prop)) else $error(msg);

// Antecedent in one cycle implies consequent in the next.
`define EPTM_ASSERT_NEXT(lbl, clk, rstn, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rstn) (ante) |=> (cons)) else $error(msg);

`endif

/* src/eptm_pkg.sv */
// Types, constants and controller/datapath interface of the EPT map engine.
package eptm_pkg;

  localparam int unsigned TablePagesDef   = 16;
  localparam int unsigned EntriesPerTable = 512;
  localparam int unsigned IdxW            = 9;
  localparam int unsigned GaW             = 48;
  localparam int unsigned HaW             = 52;
  localparam int unsigned LenW            = 40;
  localparam int unsigned EntryW          = 64;
  localparam int unsigned PagesOutW       = 5;

  localparam logic [LenW-1:0] SmallSize = LenW'(4096);
  localparam logic [LenW-1:0] BigSize   = LenW'(2 * 1024 * 1024);
  localparam logic [2:0]      MemTypeWb = 3'd6;

  typedef enum logic [1:0] {
    OP_MAP   = 2'd0,
    OP_UNMAP = 2'd1,
    OP_QUERY = 2'd2,
    OP_BAD   = 2'd3
  } op_e;

  typedef enum logic [1:0] {
    ST_OK    = 2'd0,
    ST_INVAL = 2'd1,
    ST_EXIST = 2'd2,
    ST_NOMEM = 2'd3
  } status_e;

  typedef enum logic [2:0] {
    S_CLEAR,
    S_IDLE,
    S_CHECK,
    S_ITER,
    S_RD,
    S_EVAL,
    S_CLRPG,
    S_FINISH
  } state_e;

  typedef enum logic [2:0] {
    A_DESCEND,
    A_ALLOC,
    A_LEAF,
    A_CLR_BIG,
    A_CLR_SMALL,
    A_SKIP,
    A_FAIL,
    A_DONE
  } act_e;

  typedef struct packed {
    logic    load;
    logic    iter_start;
    logic    rd;
    logic    descend;
    logic    alloc;
    logic    clr_wr;
    logic    wr_leaf;
    logic    wr_zero;
    logic    adv_small;
    logic    adv_big;
    logic    adv_skip;
    logic    rollback;
    logic    set_res;
    logic    finish;
    status_e st;
    logic    hit;
    logic    hit_big;
  } cmd_t;

  typedef struct packed {
    op_e  op;
    logic arg_bad;
    logic rem_zero;
    logic present;
    logic big;
    logic at_stop;
    logic lvl_is1;
    logic lvl_is0;
    logic pool_full;
    logic clr_last;
    logic unmap_big_ok;
    logic map_big;
    logic out_full;
  } sts_t;

endpackage

/* src/eptm_dp.sv */
// Datapath of the EPT map engine: table store, walk registers, range counters, result.
`include "assert_macros.svh"

module eptm_dp #(
  parameter int unsigned TablePages = eptm_pkg::TablePagesDef
) (
  input  logic                             clk_i,
  input  logic                             rst_ni,
  input  eptm_pkg::cmd_t                   cmd_i,
  output eptm_pkg::sts_t                   sts_o,
  input  logic [1:0]                       mode_i,
  input  logic [eptm_pkg::GaW-1:0]         guest_address_i,
  input  logic [eptm_pkg::HaW-1:0]         host_address_i,
  input  logic [eptm_pkg::LenW-1:0]        length_i,
  input  logic [2:0]                       rights_i,
  output logic                             out_valid_o,
  input  logic                             out_ready_i,
  output logic [1:0]                       status_o,
  output logic                             found_o,
  output logic [eptm_pkg::HaW-1:0]         translated_address_o,
  output logic [eptm_pkg::PagesOutW-1:0]   pages_used_o
);
  import eptm_pkg::*;

  localparam int unsigned PgW   = $clog2(TablePages);
  localparam int unsigned CntW  = $clog2(TablePages + 1);
  localparam int unsigned AddrW = PgW + IdxW;
  localparam int unsigned Depth = TablePages * EntriesPerTable;

  logic [EntryW-1:0] mem_q [Depth];

  op_e             op_q;
  logic [GaW-1:0]  ga_q, cur_q;
  logic [HaW-1:0]  ha_q, hcur_q;
  logic [LenW-1:0] len_q, off_q, rem_q;
  logic [2:0]      rights_q;
  logic            big_q, rb_q;
  logic [1:0]      lvl_q;
  logic [PgW-1:0]  tbl_q;
  logic [IdxW-1:0] clr_cnt_q;
  logic [CntW-1:0] pages_q;
  status_e         saved_q, res_st_q, out_st_q;
  logic [EntryW-1:0] rdata_q;
  logic            res_hit_q, out_found_q, out_valid_q;
  logic [HaW-1:0]  res_tr_q, out_tr_q;
  logic [PagesOutW-1:0] out_pages_q;

  logic [GaW-1:0]  cur_n;
  logic [HaW-1:0]  hcur_n;
  logic [LenW-1:0] rem_n, size, step;
  logic            big_n;
  logic [IdxW-1:0] idx;
  logic [AddrW-1:0] slot, waddr;
  logic [EntryW-1:0] wdata, ptr_e, leaf_e;
  logic            we;
  logic [HaW-1:0]  tr_n;

  // Next range position
  assign cur_n  = ga_q + GaW'(off_q);
  assign hcur_n = ha_q + HaW'(off_q);
  assign rem_n  = len_q - off_q;
  assign big_n  = (op_q == OP_MAP) && (cur_n[20:0] == '0) && (hcur_n[20:0] == '0) &&
                  (rem_n >= BigSize);

  always_comb begin
    case (lvl_q)
      2'd0:    idx = cur_q[20:12];
      2'd1:    idx = cur_q[29:21];
      2'd2:    idx = cur_q[38:30];
      default: idx = cur_q[47:39];
    endcase
  end

  assign slot = {tbl_q, idx};

  // Region covered by one missing entry at this level
  always_comb begin
    case (lvl_q)
      2'd1:    size = LenW'(64'h20_0000);
      2'd2:    size = LenW'(64'h4000_0000);
      default: size = LenW'(64'h80_0000_0000);
    endcase
    step = size - (cur_q[LenW-1:0] & (size - LenW'(1)));
  end

  always_comb begin
    ptr_e = '0;
    ptr_e[12 +: PgW] = pages_q[PgW-1:0];
    ptr_e[2:0] = 3'b111;
    leaf_e = EntryW'(hcur_q);
    leaf_e[7] = big_q;
    leaf_e[5:3] = MemTypeWb;
    leaf_e[2:0] = rights_q;
  end

  assign we    = cmd_i.alloc | cmd_i.wr_leaf | cmd_i.wr_zero | cmd_i.clr_wr;
  assign waddr = cmd_i.clr_wr ? {tbl_q, clr_cnt_q} : slot;
  assign wdata = cmd_i.alloc ? ptr_e : (cmd_i.wr_leaf ? leaf_e : '0);

  always_ff @(posedge clk_i) begin
    if (we) begin
      mem_q[waddr] <= wdata;
    end
    if (cmd_i.rd) begin
      rdata_q <= mem_q[slot];
    end
  end

  assign tr_n = !cmd_i.hit ? '0 :
                cmd_i.hit_big ? {rdata_q[51:21], ga_q[20:0]} : {rdata_q[51:12], ga_q[11:0]};

  // Payload registers
  always_ff @(posedge clk_i) begin
    if (cmd_i.load) begin
      ga_q     <= guest_address_i;
      ha_q     <= host_address_i;
      len_q    <= length_i;
      rights_q <= rights_i;
    end
    if (cmd_i.iter_start) begin
      cur_q  <= cur_n;
      hcur_q <= hcur_n;
      rem_q  <= rem_n;
    end
    if (cmd_i.rollback) begin
      len_q <= off_q;
    end
    if (cmd_i.set_res) begin
      res_st_q  <= rb_q ? saved_q : cmd_i.st;
      res_hit_q <= cmd_i.hit;
      res_tr_q  <= tr_n;
    end
    if (cmd_i.rollback) begin
      saved_q <= cmd_i.st;
    end
    if (cmd_i.finish) begin
      out_st_q    <= res_st_q;
      out_found_q <= res_hit_q;
      out_tr_q    <= res_tr_q;
      out_pages_q <= PagesOutW'(pages_q);
    end
  end

  // Control registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      op_q        <= OP_MAP;
      off_q       <= '0;
      big_q       <= 1'b0;
      rb_q        <= 1'b0;
      lvl_q       <= 2'd0;
      tbl_q       <= '0;
      clr_cnt_q   <= '0;
      pages_q     <= CntW'(1);
      out_valid_q <= 1'b0;
    end else begin
      if (cmd_i.load) begin
        op_q  <= op_e'(mode_i);
        off_q <= '0;
        rb_q  <= 1'b0;
      end
      if (cmd_i.iter_start) begin
        big_q <= big_n;
        lvl_q <= 2'd3;
        tbl_q <= '0;
      end
      if (cmd_i.descend) begin
        tbl_q <= rdata_q[12 +: PgW];
        lvl_q <= lvl_q - 2'd1;
      end
      if (cmd_i.alloc) begin
        tbl_q     <= pages_q[PgW-1:0];
        lvl_q     <= lvl_q - 2'd1;
        clr_cnt_q <= '0;
        pages_q   <= pages_q + CntW'(1);
      end
      if (cmd_i.clr_wr) begin
        clr_cnt_q <= clr_cnt_q + IdxW'(1);
      end
      if (cmd_i.adv_small) begin
        off_q <= off_q + SmallSize;
      end
      if (cmd_i.adv_big) begin
        off_q <= off_q + BigSize;
      end
      if (cmd_i.adv_skip) begin
        off_q <= (rem_q <= step) ? len_q : off_q + step;
      end
      if (cmd_i.rollback) begin
        op_q  <= OP_UNMAP;
        off_q <= '0;
        rb_q  <= 1'b1;
      end
      if (cmd_i.finish) begin
        out_valid_q <= 1'b1;
      end else if (out_ready_i) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  always_comb begin
    sts_o.op       = op_q;
    case (op_q)
      OP_MAP:   sts_o.arg_bad = ((ga_q[11:0] | ha_q[11:0] | len_q[11:0]) != '0) ||
                                (rights_q == '0);
      OP_UNMAP: sts_o.arg_bad = (ga_q[11:0] | len_q[11:0]) != '0;
      OP_QUERY: sts_o.arg_bad = 1'b0;
      default:  sts_o.arg_bad = 1'b1;
    endcase
    sts_o.rem_zero     = len_q == off_q;
    sts_o.present      = rdata_q[2:0] != '0;
    sts_o.big          = rdata_q[7];
    sts_o.lvl_is1      = lvl_q == 2'd1;
    sts_o.lvl_is0      = lvl_q == 2'd0;
    sts_o.at_stop      = big_q ? (lvl_q == 2'd1) : (lvl_q == 2'd0);
    sts_o.pool_full    = pages_q >= CntW'(TablePages);
    sts_o.clr_last     = clr_cnt_q == '1;
    sts_o.unmap_big_ok = (cur_q[20:0] == '0) && (rem_q >= BigSize);
    sts_o.map_big      = big_q;
    sts_o.out_full     = out_valid_q && !out_ready_i;
  end

  assign out_valid_o          = out_valid_q;
  assign status_o             = out_st_q;
  assign found_o              = out_found_q;
  assign translated_address_o = out_tr_q;
  assign pages_used_o         = out_pages_q;

  `EPTM_ASSERT(dp_pages_range, clk_i, rst_ni, (pages_q >= CntW'(1)) && (pages_q <= CntW'(TablePages)), "table page count out of range")
  `EPTM_ASSERT(dp_walk_level, clk_i, rst_ni, !(cmd_i.descend || cmd_i.alloc) || (lvl_q != 2'd0), "walk stepped below the last level")
  `EPTM_ASSERT_NEXT(dp_alloc_count, clk_i, rst_ni, cmd_i.alloc, pages_q == $past(pages_q) + CntW'(1), "allocation did not bump page count")

endmodule

/* src/eptm_ctrl.sv */
// Sequencer of the EPT map engine: walks, allocation, range iteration, rollback.
`include "assert_macros.svh"

module eptm_ctrl (
  input  logic           clk_i,
  input  logic           rst_ni,
  input  logic           in_valid_i,
  output logic           in_ready_o,
  input  eptm_pkg::sts_t sts_i,
  output eptm_pkg::cmd_t cmd_o
);
  import eptm_pkg::*;

  state_e  state_q, state_d;
  act_e    act;
  status_e act_st;
  logic    act_hit, act_hbig;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= S_CLEAR;
    end else begin
      state_q <= state_d;
    end
  end

  // What to do with the entry just read
  always_comb begin
    act      = A_DONE;
    act_st   = ST_OK;
    act_hit  = 1'b0;
    act_hbig = 1'b0;
    case (sts_i.op)
      OP_MAP: begin
        if (sts_i.at_stop) begin
          if (sts_i.present) begin
            act = A_FAIL; act_st = ST_EXIST;
          end else begin
            act = A_LEAF;
          end
        end else if (sts_i.big) begin
          act = A_FAIL;
          act_st = (sts_i.lvl_is1 && sts_i.present) ? ST_EXIST : ST_NOMEM;
        end else if (!sts_i.present) begin
          if (sts_i.pool_full) begin
            act = A_FAIL; act_st = ST_NOMEM;
          end else begin
            act = A_ALLOC;
          end
        end else begin
          act = A_DESCEND;
        end
      end
      OP_UNMAP: begin
        if (sts_i.lvl_is0) begin
          act = A_CLR_SMALL;
        end else if (sts_i.big) begin
          if (sts_i.lvl_is1 && sts_i.present) begin
            if (sts_i.unmap_big_ok) begin
              act = A_CLR_BIG;
            end else begin
              act = A_DONE; act_st = ST_INVAL;
            end
          end else begin
            act = A_SKIP;
          end
        end else if (!sts_i.present) begin
          act = A_SKIP;
        end else begin
          act = A_DESCEND;
        end
      end
      OP_QUERY: begin
        if (sts_i.lvl_is0) begin
          act = A_DONE; act_hit = sts_i.present;
        end else if (sts_i.big) begin
          act = A_DONE;
          act_hit = sts_i.lvl_is1 && sts_i.present;
          act_hbig = 1'b1;
        end else if (!sts_i.present) begin
          act = A_DONE;
        end else begin
          act = A_DESCEND;
        end
      end
      default: begin
        act = A_DONE; act_st = ST_INVAL;
      end
    endcase
  end

  always_comb begin
    state_d = state_q;
    case (state_q)
      S_CLEAR:  if (sts_i.clr_last) state_d = S_IDLE;
      S_IDLE:   if (in_valid_i) state_d = S_CHECK;
      S_CHECK:  state_d = sts_i.arg_bad ? S_FINISH : S_ITER;
      S_ITER: begin
        state_d = (sts_i.op != OP_QUERY && sts_i.rem_zero) ? S_FINISH : S_RD;
      end
      S_RD:     state_d = S_EVAL;
      S_EVAL: begin
        case (act)
          A_DESCEND: state_d = S_RD;
          A_ALLOC:   state_d = S_CLRPG;
          A_DONE:    state_d = S_FINISH;
          default:   state_d = S_ITER;
        endcase
      end
      S_CLRPG:  if (sts_i.clr_last) state_d = S_RD;
      S_FINISH: if (!sts_i.out_full) state_d = S_IDLE;
      default:  state_d = S_IDLE;
    endcase
  end

  always_comb begin
    cmd_o      = '0;
    cmd_o.st   = ST_OK;
    in_ready_o = 1'b0;
    case (state_q)
      S_CLEAR: cmd_o.clr_wr = 1'b1;
      S_IDLE: begin
        in_ready_o = 1'b1;
        cmd_o.load = in_valid_i;
      end
      S_CHECK: begin
        cmd_o.set_res = sts_i.arg_bad;
        cmd_o.st      = ST_INVAL;
      end
      S_ITER: begin
        if (sts_i.op != OP_QUERY && sts_i.rem_zero) begin
          cmd_o.set_res = 1'b1;
        end else begin
          cmd_o.iter_start = 1'b1;
        end
      end
      S_RD: cmd_o.rd = 1'b1;
      S_EVAL: begin
        case (act)
          A_DESCEND:   cmd_o.descend = 1'b1;
          A_ALLOC:     cmd_o.alloc = 1'b1;
          A_LEAF: begin
            cmd_o.wr_leaf   = 1'b1;
            cmd_o.adv_big   = sts_i.map_big;
            cmd_o.adv_small = !sts_i.map_big;
          end
          A_CLR_BIG: begin
            cmd_o.wr_zero = 1'b1;
            cmd_o.adv_big = 1'b1;
          end
          A_CLR_SMALL: begin
            cmd_o.wr_zero   = 1'b1;
            cmd_o.adv_small = 1'b1;
          end
          A_SKIP:      cmd_o.adv_skip = 1'b1;
          A_FAIL: begin
            cmd_o.rollback = 1'b1;
            cmd_o.st       = act_st;
          end
          default: begin
            cmd_o.set_res = 1'b1;
            cmd_o.st      = act_st;
            cmd_o.hit     = act_hit;
            cmd_o.hit_big = act_hbig;
          end
        endcase
      end
      S_CLRPG:  cmd_o.clr_wr = 1'b1;
      S_FINISH: cmd_o.finish = !sts_i.out_full;
      default:  cmd_o = '0;
    endcase
  end

  `EPTM_ASSERT(ctrl_one_write, clk_i, rst_ni, $countones({cmd_o.alloc, cmd_o.wr_leaf, cmd_o.wr_zero, cmd_o.clr_wr}) <= 1, "more than one table write in a cycle")
  `EPTM_ASSERT_NEXT(ctrl_rollback_iter, clk_i, rst_ni, cmd_o.rollback, state_q == S_ITER, "rollback did not restart range")
  `EPTM_ASSERT(ctrl_finish_free, clk_i, rst_ni, !cmd_o.finish || !sts_i.out_full, "result written over a waiting beat")

endmodule

/* src/ept_four_level_map_engine.sv */
// Top level of the four-level EPT map engine: stream ports, sequencer and datapath.
//
// Keeps a four-level extended page table (Intel entry format) in an internal
// pool of TablePages table pages of 512 64-bit entries; page 0 is the root.
// Each input beat is a map, unmap or query request; each gives exactly one
// result beat carrying status, query hit, translated address and the count of
// table pages in use. After reset the block clears the root page with
// s_axis_tready_o low. Work is one request at a time over a single-port
// table store with registered read data: every table level visited takes
// an address step, then a decode step. Map or unmap walks again from the
// root for each 4 KiB or 2 MiB leaf and zeroes each newly allocated table
// page entry by entry. Unmapped stretches are skipped one missing table
// region at a time. A failed map replays its placed range as an unmap
// before it reports. The next request is taken while a finished result
// still waits on the master side.

module ept_four_level_map_engine #(
  parameter int unsigned TablePages = eptm_pkg::TablePagesDef
) (
  input  logic         clk_i,
  input  logic         rst_ni,
  input  logic         s_axis_tvalid_i,
  output logic         s_axis_tready_o,
  // [1:0] mode, [49:2] guest_address, [101:50] host_address,
  // [141:102] length, [144:142] rights, [151:145] zero
  input  logic [151:0] s_axis_tdata_i,
  output logic         m_axis_tvalid_o,
  input  logic         m_axis_tready_i,
  // [1:0] status, [2] found, [54:3] translated_address, [59:55] pages_used,
  // [63:60] zero
  output logic [63:0]  m_axis_tdata_o
);
  import eptm_pkg::*;

  cmd_t cmd;
  sts_t sts;

  logic [1:0]           status;
  logic                 found;
  logic [HaW-1:0]       tr_addr;
  logic [PagesOutW-1:0] pages_used;

  eptm_ctrl u_ctrl (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (s_axis_tvalid_i),
    .in_ready_o (s_axis_tready_o),
    .sts_i      (sts),
    .cmd_o      (cmd)
  );

  eptm_dp #(
    .TablePages (TablePages)
  ) u_dp (
    .clk_i                (clk_i),
    .rst_ni               (rst_ni),
    .cmd_i                (cmd),
    .sts_o                (sts),
    .mode_i               (s_axis_tdata_i[1:0]),
    .guest_address_i      (s_axis_tdata_i[49:2]),
    .host_address_i       (s_axis_tdata_i[101:50]),
    .length_i             (s_axis_tdata_i[141:102]),
    .rights_i             (s_axis_tdata_i[144:142]),
    .out_valid_o          (m_axis_tvalid_o),
    .out_ready_i          (m_axis_tready_i),
    .status_o             (status),
    .found_o              (found),
    .translated_address_o (tr_addr),
    .pages_used_o         (pages_used)
  );

  // Result beat packing, lowest field first
  assign m_axis_tdata_o = {4'b0, pages_used, tr_addr, found, status};

endmodule

/* sim/tb_ept_four_level_map_engine.sv */
// Self-checking testbench for the four-level EPT map engine: directed table plus random traffic.
`timescale 1ns / 100ps

module tb_ept_four_level_map_engine;
  import eptm_pkg::*;

  localparam int unsigned  NumPages    = TablePagesDef;
  localparam longint       CycleLimit  = 4_000_000;
  localparam int unsigned  RandomBeats = 880;
  localparam logic [63:0]  PageBytes   = 64'h1000;
  localparam logic [63:0]  LargeBytes  = 64'h20_0000;
  localparam logic [63:0]  AddrBits    = 64'h000F_FFFF_FFFF_F000;
  localparam logic [63:0]  AccessBits  = 64'h7;
  localparam logic [63:0]  LargeBit    = 64'h80;
  localparam logic [63:0]  WbBits      = 64'(MemTypeWb) << 3;

  // One request beat; typed rows carry a hand-written expected status/hit/address.
  typedef struct {
    op_e         mode;
    logic [47:0] ga;
    logic [51:0] ha;
    logic [39:0] len;
    logic [2:0]  rights;
    bit          typed;
    status_e     st;
    bit          hit;
    logic [51:0] tr;
  } req_t;

  typedef struct {
    status_e     st;
    bit          hit;
    logic [51:0] tr;
    logic [4:0]  pages;
  } res_t;

  logic         clk_i = 1'b0;
  logic         rst_ni = 1'b0;
  logic         s_axis_tvalid_i = 1'b0;
  logic         s_axis_tready_o;
  logic [151:0] s_axis_tdata_i = '0;
  logic         m_axis_tvalid_o;
  logic         m_axis_tready_i = 1'b0;
  logic [63:0]  m_axis_tdata_o;

  ept_four_level_map_engine uut (
    .clk_i,
    .rst_ni,
    .s_axis_tvalid_i,
    .s_axis_tready_o,
    .s_axis_tdata_i,
    .m_axis_tvalid_o,
    .m_axis_tready_i,
    .m_axis_tdata_o
  );

  always begin
    #6 clk_i = 1'b1;
    #6 clk_i = 1'b0;
  end

  // Shadow page-table pool and allocation count.
  logic [63:0] pt_mem [0:NumPages*EntriesPerTable-1];
  int unsigned pt_used;

  res_t pending_results[$];
  int   err_cnt = 0;
  bit   calm = 1'b0;  // no gaps or stalls on either side while set
  longint cycle_cnt = 0;

  function automatic int unsigned lvl_index(input logic [47:0] ga, input int lvl);
    return int'((ga >> (12 + 9 * lvl)) & 48'h1FF);
  endfunction

  // Walk from the root to level stop; returns 0 with fail_lvl on a large entry or on a missing one it cannot create.
  function automatic bit pt_walk(input logic [47:0] ga, input bit create, input int stop,
                                 output int unsigned slot, output int fail_lvl);
    int unsigned tbl;
    int unsigned s;
    logic [63:0] e;
    tbl = 0;
    slot = 0;
    fail_lvl = 0;
    for (int lvl = 3; lvl > stop; lvl--) begin
      s = tbl * EntriesPerTable + lvl_index(ga, lvl);
      e = pt_mem[s];
      if ((e & LargeBit) != 0) begin
        fail_lvl = lvl;
        return 1'b0;
      end
      if ((e & AccessBits) == 0) begin
        if (!create || pt_used >= NumPages) begin
          fail_lvl = lvl;
          return 1'b0;
        end
        for (int i = 0; i < EntriesPerTable; i++) pt_mem[pt_used * EntriesPerTable + i] = '0;
        e = (64'(pt_used) << 12) | AccessBits;
        pt_used++;
        pt_mem[s] = e;
      end
      tbl = int'(((e & AddrBits) >> 12) % NumPages);
    end
    slot = tbl * EntriesPerTable + lvl_index(ga, stop);
    return 1'b1;
  endfunction

  function automatic status_e pt_unmap(input logic [47:0] ga, input logic [63:0] len);
    logic [63:0] off, size, step;
    logic [47:0] cur;
    int unsigned s;
    int fl;
    logic [63:0] e;
    off = 0;
    if (((64'(ga) | len) & (PageBytes - 1)) != 0) return ST_INVAL;
    while (off < len) begin
      cur = 48'(64'(ga) + off);
      if (pt_walk(cur, 1'b0, 1, s, fl)) begin
        e = pt_mem[s];
        if ((e & AccessBits) != 0 && (e & LargeBit) != 0) begin
          if ((64'(cur) % LargeBytes) != 0 || len - off < LargeBytes) return ST_INVAL;
          pt_mem[s] = '0;
          off += LargeBytes;
          continue;
        end
        if (pt_walk(cur, 1'b0, 0, s, fl)) begin
          pt_mem[s] = '0;
          off += PageBytes;
          continue;
        end
      end
      // skip to the end of the region the missing entry would cover
      size = 64'd1 << (12 + 9 * fl);
      step = size - (64'(cur) & (size - 1));
      if (len - off <= step) off = len;
      else off += step;
    end
    return ST_OK;
  endfunction

  function automatic status_e pt_map(input logic [47:0] ga, input logic [51:0] ha,
                                     input logic [63:0] len, input logic [2:0] rights);
    logic [63:0] off, flags, e;
    logic [47:0] cur;
    logic [51:0] hcur;
    bit big;
    int unsigned s;
    int fl;
    status_e dummy;
    off = 0;
    if (((64'(ga) | 64'(ha) | len) & (PageBytes - 1)) != 0) return ST_INVAL;
    if (rights == 0) return ST_INVAL;
    flags = WbBits | 64'(rights);
    while (off < len) begin
      cur  = 48'(64'(ga) + off);
      hcur = 52'(64'(ha) + off);
      big  = (64'(cur) % LargeBytes) == 0 && (64'(hcur) % LargeBytes) == 0 &&
             len - off >= LargeBytes;
      if (!big && pt_walk(cur, 1'b0, 1, s, fl)) begin
        e = pt_mem[s];
        if ((e & AccessBits) != 0 && (e & LargeBit) != 0) begin
          dummy = pt_unmap(ga, off);
          return ST_EXIST;
        end
      end
      if (!pt_walk(cur, 1'b1, big ? 1 : 0, s, fl)) begin
        dummy = pt_unmap(ga, off);
        return ST_NOMEM;
      end
      if ((pt_mem[s] & AccessBits) != 0) begin
        dummy = pt_unmap(ga, off);
        return ST_EXIST;
      end
      pt_mem[s] = 64'(hcur) | flags | (big ? LargeBit : 64'd0);
      off += big ? LargeBytes : PageBytes;
    end
    return ST_OK;
  endfunction

  function automatic bit pt_translate(input logic [47:0] ga, output logic [51:0] ha);
    int unsigned s;
    int fl;
    logic [63:0] e;
    ha = '0;
    if (pt_walk(ga & ~48'h1F_FFFF, 1'b0, 1, s, fl)) begin
      e = pt_mem[s];
      if ((e & AccessBits) != 0 && (e & LargeBit) != 0) begin
        ha = 52'((e & AddrBits & ~(LargeBytes - 1)) | 64'(ga[20:0]));
        return 1'b1;
      end
    end
    if (!pt_walk(ga & ~48'hFFF, 1'b0, 0, s, fl)) return 1'b0;
    e = pt_mem[s];
    if ((e & AccessBits) == 0) return 1'b0;
    ha = 52'((e & AddrBits) | 64'(ga[11:0]));
    return 1'b1;
  endfunction

  // Apply one accepted request to the shadow table and give its result.
  function automatic res_t pt_apply(input req_t r);
    res_t o;
    o.st = ST_OK;
    o.hit = 1'b0;
    o.tr = '0;
    case (r.mode)
      OP_MAP:   o.st = pt_map(r.ga, r.ha, 64'(r.len), r.rights);
      OP_UNMAP: o.st = pt_unmap(r.ga, 64'(r.len));
      OP_QUERY: o.hit = pt_translate(r.ga, o.tr);
      default:  o.st = ST_INVAL;
    endcase
    o.pages = 5'(pt_used);
    return o;
  endfunction

  // Drive one request beat; the prediction is queued on the accepting edge.
  task automatic issue(input req_t r);
    int unsigned gap;
    res_t o;
    gap = calm ? 0 : $urandom_range(0, 11);
    if (gap > 0) begin
      s_axis_tvalid_i <= 1'b0;
      repeat (gap) @(posedge clk_i);
    end
    s_axis_tvalid_i <= 1'b1;
    s_axis_tdata_i  <= {7'd0, r.rights, r.len, r.ha, r.ga, r.mode};
    do @(posedge clk_i); while (!s_axis_tready_o);
    o = pt_apply(r);
    if (r.typed) begin
      o.st  = r.st;
      o.hit = r.hit;
      o.tr  = r.tr;
    end
    pending_results.push_back(o);
  endtask

  // Result side: random stalls per beat, checked against the oldest prediction.
  int unsigned stall = 0;
  always @(posedge clk_i) begin
    res_t want;
    if (rst_ni && m_axis_tvalid_o && m_axis_tready_i) begin
      if (pending_results.size() == 0) begin
        $error("result beat with nothing expected: %h", m_axis_tdata_o);
        err_cnt++;
      end else begin
        want = pending_results.pop_front();
        if (m_axis_tdata_o[1:0] != want.st) begin
          $error("status: expected %0d, got %0d", want.st, m_axis_tdata_o[1:0]);
          err_cnt++;
        end
        if (m_axis_tdata_o[2] != want.hit) begin
          $error("found: expected %0d, got %0d", want.hit, m_axis_tdata_o[2]);
          err_cnt++;
        end
        if (m_axis_tdata_o[54:3] != want.tr) begin
          $error("translated_address: expected %h, got %h", want.tr, m_axis_tdata_o[54:3]);
          err_cnt++;
        end
        if (m_axis_tdata_o[59:55] != want.pages) begin
          $error("pages_used: expected %0d, got %0d", want.pages, m_axis_tdata_o[59:55]);
          err_cnt++;
        end
      end
      stall = calm ? 0 : $urandom_range(0, 11);
    end
    m_axis_tready_i <= (stall == 0);
    if (stall > 0) stall--;
  end

  // Watchdog, sized from a worst run: slow multi-page maps with rollback, full gaps and stalls.
  always @(posedge clk_i) begin
    cycle_cnt++;
    if (cycle_cnt > CycleLimit) begin
      $display("DONE: errors detected");
      $finish;
    end
  end

  // Random request in a small guest window so table pages get reused; some noise.
  function automatic req_t rand_req();
    req_t r;
    logic [8:0] l4, l3;
    bit big;
    r.typed = 1'b0;
    r.st = ST_OK;
    r.hit = 1'b0;
    r.tr = '0;
    if ($urandom_range(0, 99) < 12) begin
      r.mode   = op_e'($urandom_range(0, 3));
      r.ga     = 48'({$urandom, $urandom});
      r.ha     = 52'({$urandom, $urandom});
      r.len    = 40'({$urandom, $urandom});
      r.rights = 3'($urandom);
      return r;
    end
    case ($urandom_range(0, 99)) inside
      [0:39]:  r.mode = OP_MAP;
      [40:64]: r.mode = OP_UNMAP;
      default: r.mode = OP_QUERY;
    endcase
    l4  = ($urandom_range(0, 99) < 4) ? 9'($urandom) : 9'd0;
    l3  = ($urandom_range(0, 99) < 4) ? 9'($urandom) : 9'd0;
    big = $urandom_range(0, 3) == 0;
    r.ga = {l4, l3, 3'($urandom_range(0, 7)), 6'd0, 9'($urandom), 12'd0};
    r.ha = 52'({$urandom, $urandom}) & ~52'hFFF;
    r.rights = 3'($urandom_range(1, 7));
    r.len = 40'($urandom_range(0, 8)) << 12;
    if (big) begin
      r.ga[20:12] = '0;
      r.ha[20:0]  = '0;
      r.len = 40'($urandom_range(1, 2)) << 21;
    end
    if (r.mode == OP_QUERY) r.ga[20:0] = big ? 21'($urandom) : {r.ga[20:12], 12'($urandom)};
    return r;
  endfunction

  req_t dir_rows[$];

  initial begin
    for (int i = 0; i < NumPages * EntriesPerTable; i++) pt_mem[i] = '0;
    pt_used = 1;

    // mode, guest, host, length, rights, typed, status, found, translated
    dir_rows.push_back('{OP_QUERY, 48'h0, 52'h0, 40'h0, 3'd0, 1, ST_OK, 0, 52'h0});
    dir_rows.push_back('{OP_BAD, '1, '1, '1, 3'd7, 1, ST_INVAL, 0, 52'h0});
    dir_rows.push_back('{OP_MAP, 48'h1, 52'h0, 40'h1000, 3'd7, 1, ST_INVAL, 0, 52'h0});
    dir_rows.push_back('{OP_MAP, 48'h1000, 52'h1000, 40'h1000, 3'd0, 1, ST_INVAL, 0, 52'h0});
    dir_rows.push_back('{OP_MAP, 48'h1000, 52'h10, 40'h1000, 3'd7, 1, ST_INVAL, 0, 52'h0});
    dir_rows.push_back('{OP_UNMAP, 48'h1000, 52'h0, 40'hFFF, 3'd0, 1, ST_INVAL, 0, 52'h0});
    dir_rows.push_back('{OP_MAP, 48'h1000, 52'h5000, 40'h0, 3'd7, 1, ST_OK, 0, 52'h0});
    dir_rows.push_back('{OP_UNMAP, 48'h1000, 52'h0, 40'h0, 3'd0, 1, ST_OK, 0, 52'h0});
    dir_rows.push_back('{OP_MAP, 48'h1000, 52'h5000, 40'h3000, 3'd7, 0, ST_OK, 0, 52'h0});
    dir_rows.push_back('{OP_QUERY, 48'h1234, 52'h0, 40'h0, 3'd0, 0, ST_OK, 0, 52'h0});
    // overlap with live small leaves
    dir_rows.push_back('{OP_MAP, 48'h2000, 52'h9000, 40'h2000, 3'd1, 1, ST_EXIST, 0, 52'h0});
    dir_rows.push_back('{OP_MAP, 48'h200000, 52'h400000, 40'h400000, 3'd3, 0, ST_OK, 0, 52'h0});
    dir_rows.push_back('{OP_QUERY, 48'h3FFFFF, 52'h0, 40'h0, 3'd0, 0, ST_OK, 0, 52'h0});
    // unmap may not split a large leaf
    dir_rows.push_back('{OP_UNMAP, 48'h300000, 52'h0, 40'h1000, 3'd0, 1, ST_INVAL, 0, 52'h0});
    dir_rows.push_back('{OP_MAP, 48'h201000, 52'h7000, 40'h1000, 3'd4, 1, ST_EXIST, 0, 52'h0});
    dir_rows.push_back('{OP_UNMAP, 48'h200000, 52'h0, 40'h200000, 3'd0, 0, ST_OK, 0, 52'h0});
    // both addresses wrap past their top
    dir_rows.push_back('{OP_MAP, 48'hFFFF_FFFF_F000, 52'hF_FFFF_FFFF_F000, 40'h2000, 3'd5,
                         0, ST_OK, 0, 52'h0});
    dir_rows.push_back('{OP_QUERY, 48'hFFFF_FFFF_FFFF, 52'h0, 40'h0, 3'd0, 0, ST_OK, 0, 52'h0});
    dir_rows.push_back('{OP_QUERY, 48'h0, 52'h0, 40'h0, 3'd0, 0, ST_OK, 0, 52'h0});
    dir_rows.push_back('{OP_UNMAP, 48'h0, 52'h0, 40'hFF_FFFF_F000, 3'd0, 0, ST_OK, 0, 52'h0});
    dir_rows.push_back('{OP_MAP, 48'hFFFF_FFFF_E000, 52'hF_FFFF_FFFF_E000, 40'h1000, 3'd7,
                         0, ST_OK, 0, 52'h0});
    dir_rows.push_back('{OP_QUERY, 48'hFFFF_FFFF_EABC, 52'h0, 40'h0, 3'd0, 0, ST_OK, 0, 52'h0});

    repeat (10) @(posedge clk_i);
    rst_ni <= 1'b1;

    foreach (dir_rows[i]) issue(dir_rows[i]);

    for (int n = 0; n < RandomBeats; n++) begin
      if (n % 200 == 100) calm = 1'b1;
      if (n % 200 == 160) calm = 1'b0;
      if (n == RandomBeats / 2) begin
        // hold off until the result side has drained
        s_axis_tvalid_i <= 1'b0;
        while (pending_results.size() != 0) @(posedge clk_i);
      end
      issue(rand_req());
    end
    s_axis_tvalid_i <= 1'b0;

    while (pending_results.size() != 0) @(posedge clk_i);
    repeat (50) @(posedge clk_i);
    if (err_cnt == 0) begin
      $display("DONE: 0 errors");
    end else begin
      $display("DONE: errors detected");
    end
    $finish;
  end

endmodule
